[rtl/core/lot_pkg.sv]
// Shared types for the layer order table: command codes, sequencer states, cell controls.
package lot_pkg;

	typedef enum logic [1:0] {
		MODE_ALLOC = 2'd0,
		MODE_SET   = 2'd1,
		MODE_FREE  = 2'd2,
		MODE_NONE  = 2'd3
	} lot_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_APPLY
	} lot_state_t;

	// Per-cycle orders broadcast to every cell of the chain
	typedef struct packed {
		logic shift_up;    // slot takes its lower neighbor, heights in range rise by one
		logic shift_down;  // slot takes its upper neighbor, heights in range drop by one
		logic place;       // target layer lands at the new height
		logic hide;        // target layer leaves the order
		logic grow;        // top rises by one
		logic drop_use;    // target layer is released
		logic alloc;       // allocated layer is claimed
	} lot_ctl_t;

endpackage

[rtl/core/lot_cell.sv]
// One cell of the order chain: the slot at its height, and in-use flag and height of its layer id.
module lot_cell import lot_pkg::*; #(
	parameter int IW = 4,
	parameter int HW = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [IW-1:0]        idx,
	input  lot_ctl_t             ctl,
	input  logic signed [HW-1:0] slot_lo,
	input  logic signed [HW-1:0] slot_hi,
	input  logic signed [HW-1:0] ht_lo,
	input  logic signed [HW-1:0] ht_hi,
	input  logic signed [HW-1:0] nh,
	input  logic [IW-1:0]        tgt_id,
	input  logic [IW-1:0]        alloc_id,
	input  logic [IW-1:0]        slot_below,
	input  logic [IW-1:0]        slot_above,
	output logic [IW-1:0]        slot,
	output logic                 used,
	output logic signed [IW:0]   height
);

	localparam logic signed [IW:0] H_ONE  = (IW+1)'(1);
	localparam logic signed [IW:0] H_NEG1 = '1;

	logic [IW-1:0]        slot_q;
	logic                 used_q;
	logic signed [IW:0]   height_q;
	logic signed [HW-1:0] hpos;
	logic signed [HW-1:0] ht_w;
	logic                 in_slot_rng;
	logic                 in_ht_rng;
	logic                 is_tgt;

	assign hpos        = signed'(HW'(idx));
	assign ht_w        = HW'(height_q);
	assign in_slot_rng = (slot_lo <= hpos) && (hpos <= slot_hi);
	assign in_ht_rng   = (ht_lo <= ht_w) && (ht_w <= ht_hi);
	assign is_tgt      = (idx == tgt_id);

	// Shift the slot from a neighbor or land the moved layer here
	always_ff @(posedge clk) begin
		if (ctl.place && hpos == nh) begin
			slot_q <= tgt_id;
		end else if (ctl.shift_up && in_slot_rng) begin
			slot_q <= slot_below;
		end else if (ctl.shift_down && in_slot_rng) begin
			slot_q <= slot_above;
		end
	end

	// Track this layer's height and ownership
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= 1'b0;
			height_q <= H_NEG1;
		end else begin
			if (ctl.alloc && idx == alloc_id) begin
				used_q <= 1'b1;
			end else if (ctl.drop_use && is_tgt) begin
				used_q <= 1'b0;
			end
			if (ctl.place && is_tgt) begin
				height_q <= (IW+1)'(nh);
			end else if (ctl.hide && is_tgt) begin
				height_q <= H_NEG1;
			end else if (ctl.shift_up && in_ht_rng) begin
				height_q <= height_q + H_ONE;
			end else if (ctl.shift_down && in_ht_rng) begin
				height_q <= height_q - H_ONE;
			end
		end
	end

	assign slot   = slot_q;
	assign used   = used_q;
	assign height = height_q;

endmodule

[rtl/core/lot_free_search.sv]
// Two-level first-free-layer search: registered group encoders, then a group pick.
module lot_free_search #(
	parameter int MAX_LAYERS = 16,
	parameter int IW         = 4
) (
	input  logic                  clk,
	input  logic [MAX_LAYERS-1:0] used,
	output logic                  found,
	output logic [IW-1:0]         free_id
);

	localparam int NG = (MAX_LAYERS + 15) / 16;
	localparam int GW = (NG > 1) ? $clog2(NG) : 1;
	localparam int PW = NG * 16;

	logic [PW-1:0] pad_v;
	logic [NG-1:0] grp_any_c;
	logic [3:0]    grp_idx_c [NG];
	logic [NG-1:0] grp_any_s1;
	logic [3:0]    grp_idx_s1 [NG];
	logic [GW-1:0] grp_sel;
	logic [GW+3:0] id_full;

	// Find the lowest free entry in each group of sixteen
	always_comb begin
		pad_v = '1;
		pad_v[MAX_LAYERS-1:0] = used;
		for (int g = 0; g < NG; g++) begin
			grp_any_c[g] = 1'b0;
			grp_idx_c[g] = '0;
			for (int k = 15; k >= 0; k--) begin
				if (!pad_v[g*16 + k]) begin
					grp_any_c[g] = 1'b1;
					grp_idx_c[g] = 4'(k);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_any_s1 <= grp_any_c;
		for (int g = 0; g < NG; g++) begin
			grp_idx_s1[g] <= grp_idx_c[g];
		end
	end

	// Pick the lowest group that has a free entry
	always_comb begin
		grp_sel = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_any_s1[g]) begin
				grp_sel = GW'(g);
			end
		end
	end

	assign found   = |grp_any_s1;
	assign id_full = {grp_sel, grp_idx_s1[grp_sel]};
	assign free_id = IW'(id_full);

endmodule

[rtl/core/layer_order_table.sv]
// Top level of the layer order table: command sequencer, cell chain and result register.
//
// Keeps the stacking order of MAX_LAYERS display layers in a chain of cells, one per
// height and layer id; a reorder shifts every affected slot to its neighbor at once.
// Each request passes the CALC state, to look up the addressed layer, clamp the height
// and work out the shift range, then the APPLY state, in which the cell chain shifts
// and renumbers once the output register is free. The next request is taken in the
// same cycle the result is loaded into the output register, not before. Slots above
// the top height are never read and start out undefined.
module layer_order_table import lot_pkg::*; #(
	parameter int MAX_LAYERS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        mode,
	input  logic [3:0]        layer_id,
	input  logic signed [5:0] height_request,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              alloc_ok,
	output logic [3:0]        allocated_id,
	output logic signed [4:0] layer_height,
	output logic signed [4:0] top_height,
	output logic              redraw_valid,
	output logic [3:0]        map_from_layer,
	output logic [3:0]        redraw_low,
	output logic signed [4:0] redraw_high
);

	localparam int IW  = $clog2(MAX_LAYERS);
	localparam int HW  = $clog2(MAX_LAYERS + 1) + 1;
	localparam int CW  = (HW > 6) ? HW : 6;
	localparam int XW  = (IW > 4) ? IW : 4;
	localparam int NID = (MAX_LAYERS < 16) ? MAX_LAYERS : 16;

	localparam logic signed [HW-1:0] H_ONE  = HW'(1);
	localparam logic signed [HW-1:0] H_ZERO = '0;
	localparam logic signed [HW-1:0] H_NEG1 = '1;
	localparam logic signed [IW:0]   T_ONE  = (IW+1)'(1);
	localparam logic signed [IW:0]   T_NEG1 = '1;
	localparam logic signed [CW-1:0] C_NEG1 = '1;

	// sequencer
	lot_state_t state_q, state_nxt;
	logic       accept;
	logic       out_free;
	logic       fire;

	// latched request
	lot_mode_t         mode_q;
	logic [3:0]        id_q;
	logic signed [5:0] req_q;

	// cell chain
	logic [IW-1:0]         slot_v   [MAX_LAYERS];
	logic signed [IW:0]    ht_v     [MAX_LAYERS];
	logic [MAX_LAYERS-1:0] used_v;
	lot_ctl_t              ctl_cells;

	// lookup and clamp
	logic                 sel_used;
	logic signed [IW:0]   sel_ht;
	logic signed [HW-1:0] old_h;
	logic signed [HW-1:0] top_w;
	logic signed [HW-1:0] limit;
	logic signed [CW-1:0] req_x;
	logic signed [CW-1:0] lim_x;
	logic signed [CW-1:0] nh_x;
	logic signed [HW-1:0] nh_c;
	logic                 act;
	logic                 changed_c;
	logic                 lower_c, hide_c, raise_c, show_c;
	lot_ctl_t             ctl_c;
	logic signed [HW-1:0] slot_lo_c, slot_hi_c, ht_lo_c, ht_hi_c;
	logic signed [HW-1:0] map_c, lo_c, hi_c, lh_c;
	logic [XW-1:0]        id_x;

	// registered plan
	lot_ctl_t             ctl_q;
	logic signed [HW-1:0] slot_lo_q, slot_hi_q, ht_lo_q, ht_hi_q, nh_q;
	logic signed [HW-1:0] map_q, lo_q, hi_q, lh_q;
	logic                 changed_q;
	logic [IW-1:0]        tgt_q;

	// allocation and top
	logic                 found;
	logic [IW-1:0]        free_id;
	logic signed [IW:0]   top_q;
	logic signed [IW:0]   top_nxt;
	logic [XW-1:0]        new_x;

	// result register
	logic                 out_valid_q;
	logic                 alloc_ok_q;
	logic [3:0]           allocated_id_q;
	logic signed [4:0]    layer_height_q;
	logic signed [4:0]    top_height_q;
	logic                 redraw_valid_q;
	logic [3:0]           map_from_q;
	logic [3:0]           redraw_low_q;
	logic signed [4:0]    redraw_high_q;
	logic signed [CW-1:0] lh_o, top_o, map_o, lo_o, hi_o;

	// Take a request when idle, or in the cycle the previous result is loaded
	assign out_free = !out_valid_q || !out_stall;
	assign fire     = (state_q == ST_APPLY) && out_free;
	assign in_stall = !((state_q == ST_IDLE) || fire);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = ST_CALC;
				end
			end
			ST_CALC: begin
				state_nxt = ST_APPLY;
			end
			ST_APPLY: begin
				if (fire) begin
					state_nxt = accept ? ST_CALC : ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Hold the accepted request
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= lot_mode_t'(mode);
			id_q   <= layer_id;
			req_q  <= height_request;
		end
	end

	// Look up the addressed layer; ids past the table read as hidden and unused
	always_comb begin
		sel_used = 1'b0;
		sel_ht   = T_NEG1;
		for (int j = 0; j < NID; j++) begin
			if (id_q == 4'(j)) begin
				sel_used = used_v[j];
				sel_ht   = ht_v[j];
			end
		end
	end

	assign id_x  = XW'(id_q);
	assign old_h = HW'(sel_ht);
	assign top_w = HW'(top_q);

	// Clamp the request and plan the shift
	always_comb begin
		act       = sel_used && (mode_q == MODE_SET || mode_q == MODE_FREE);
		limit     = old_h[HW-1] ? (top_w + H_ONE) : top_w;
		req_x     = (mode_q == MODE_FREE) ? C_NEG1 : CW'(req_q);
		lim_x     = CW'(limit);
		if (req_x > lim_x) begin
			nh_x = lim_x;
		end else if (req_x < C_NEG1) begin
			nh_x = C_NEG1;
		end else begin
			nh_x = req_x;
		end
		nh_c      = HW'(nh_x);
		changed_c = act && (nh_c != old_h);
		lower_c   = changed_c && (old_h > nh_c) && !nh_c[HW-1];
		hide_c    = changed_c && nh_c[HW-1];
		raise_c   = changed_c && (nh_c > old_h) && !old_h[HW-1];
		show_c    = changed_c && old_h[HW-1];

		slot_lo_c = H_ZERO;
		slot_hi_c = H_NEG1;
		ht_lo_c   = H_ZERO;
		ht_hi_c   = H_NEG1;
		map_c     = H_ZERO;
		lo_c      = H_ZERO;
		hi_c      = H_NEG1;
		if (lower_c) begin
			slot_lo_c = nh_c + H_ONE;
			slot_hi_c = old_h;
			ht_lo_c   = nh_c;
			ht_hi_c   = old_h - H_ONE;
			map_c     = nh_c + H_ONE;
			lo_c      = nh_c + H_ONE;
			hi_c      = old_h;
		end else if (hide_c) begin
			slot_lo_c = old_h;
			slot_hi_c = top_w - H_ONE;
			ht_lo_c   = old_h + H_ONE;
			ht_hi_c   = top_w;
			hi_c      = old_h - H_ONE;
		end else if (raise_c) begin
			slot_lo_c = old_h;
			slot_hi_c = nh_c - H_ONE;
			ht_lo_c   = old_h + H_ONE;
			ht_hi_c   = nh_c;
			map_c     = nh_c;
			lo_c      = nh_c;
			hi_c      = nh_c;
		end else if (show_c) begin
			slot_lo_c = nh_c + H_ONE;
			slot_hi_c = top_w + H_ONE;
			ht_lo_c   = nh_c;
			ht_hi_c   = top_w;
			map_c     = nh_c;
			lo_c      = nh_c;
			hi_c      = nh_c;
		end

		ctl_c.shift_up   = lower_c || show_c;
		ctl_c.shift_down = hide_c || raise_c;
		ctl_c.place      = raise_c || lower_c || show_c;
		ctl_c.hide       = hide_c;
		ctl_c.grow       = show_c;
		ctl_c.drop_use   = act && (mode_q == MODE_FREE);
		ctl_c.alloc      = (mode_q == MODE_ALLOC);

		if (mode_q == MODE_ALLOC || (act && mode_q == MODE_FREE)) begin
			lh_c = H_NEG1;
		end else if (act) begin
			lh_c = nh_c;
		end else begin
			lh_c = old_h;
		end
	end

	// Register the plan for the chain update
	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			ctl_q     <= ctl_c;
			slot_lo_q <= slot_lo_c;
			slot_hi_q <= slot_hi_c;
			ht_lo_q   <= ht_lo_c;
			ht_hi_q   <= ht_hi_c;
			nh_q      <= nh_c;
			map_q     <= map_c;
			lo_q      <= lo_c;
			hi_q      <= hi_c;
			lh_q      <= lh_c;
			changed_q <= changed_c;
			tgt_q     <= id_x[IW-1:0];
		end
	end

	lot_free_search #(
		.MAX_LAYERS (MAX_LAYERS),
		.IW         (IW)
	) u_free (
		.clk     (clk),
		.used    (used_v),
		.found   (found),
		.free_id (free_id)
	);

	// Drive the chain only in the update cycle
	always_comb begin
		ctl_cells = '0;
		if (fire) begin
			ctl_cells       = ctl_q;
			ctl_cells.alloc = ctl_q.alloc && found;
		end
	end

	for (genvar i = 0; i < MAX_LAYERS; i++) begin : g_cell
		logic [IW-1:0] below;
		logic [IW-1:0] above;
		if (i == 0) begin : g_first
			assign below = slot_v[i];
		end else begin : g_mid_lo
			assign below = slot_v[i-1];
		end
		if (i == MAX_LAYERS - 1) begin : g_last
			assign above = slot_v[i];
		end else begin : g_mid_hi
			assign above = slot_v[i+1];
		end
		lot_cell #(
			.IW (IW),
			.HW (HW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.idx        (IW'(i)),
			.ctl        (ctl_cells),
			.slot_lo    (slot_lo_q),
			.slot_hi    (slot_hi_q),
			.ht_lo      (ht_lo_q),
			.ht_hi      (ht_hi_q),
			.nh         (nh_q),
			.tgt_id     (tgt_q),
			.alloc_id   (free_id),
			.slot_below (below),
			.slot_above (above),
			.slot       (slot_v[i]),
			.used       (used_v[i]),
			.height     (ht_v[i])
		);
	end

	// Advance the top height
	always_comb begin
		top_nxt = top_q;
		if (ctl_cells.grow) begin
			top_nxt = top_q + T_ONE;
		end else if (ctl_cells.hide) begin
			top_nxt = top_q - T_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= T_NEG1;
		end else begin
			top_q <= top_nxt;
		end
	end

	// Wrap results to the field widths
	assign new_x = XW'(free_id);
	assign lh_o  = CW'(lh_q);
	assign top_o = CW'(top_nxt);
	assign map_o = CW'(map_q);
	assign lo_o  = CW'(lo_q);
	assign hi_o  = CW'(hi_q);

	// Load the result register; hold it while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			alloc_ok_q     <= ctl_cells.alloc;
			allocated_id_q <= ctl_cells.alloc ? new_x[3:0] : 4'd0;
			layer_height_q <= lh_o[4:0];
			top_height_q   <= top_o[4:0];
			redraw_valid_q <= changed_q;
			map_from_q     <= map_o[3:0];
			redraw_low_q   <= lo_o[3:0];
			redraw_high_q  <= hi_o[4:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign alloc_ok       = alloc_ok_q;
	assign allocated_id   = allocated_id_q;
	assign layer_height   = layer_height_q;
	assign top_height     = top_height_q;
	assign redraw_valid   = redraw_valid_q;
	assign map_from_layer = map_from_q;
	assign redraw_low     = redraw_low_q;
	assign redraw_high    = redraw_high_q;

endmodule

[tb/sv/layer_order_table_tb.sv]
// Self-checking testbench for the layer order table: command stimulus, stacking predictor, result checks.
module layer_order_table_tb import lot_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LAYERS      = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 20;

	typedef struct {
		logic              alloc_ok;
		logic [3:0]        allocated_id;
		logic signed [4:0] layer_height;
		logic signed [4:0] top_height;
		logic              redraw_valid;
		logic [3:0]        map_from_layer;
		logic [3:0]        redraw_low;
		logic signed [4:0] redraw_high;
	} layer_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        mode = MODE_NONE;
	logic [3:0]        layer_id = '0;
	logic signed [5:0] height_request = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              alloc_ok;
	logic [3:0]        allocated_id;
	logic signed [4:0] layer_height;
	logic signed [4:0] top_height;
	logic              redraw_valid;
	logic [3:0]        map_from_layer;
	logic [3:0]        redraw_low;
	logic signed [4:0] redraw_high;

	// Predicted stacking state
	bit  layer_claimed [LAYERS];
	int  layer_level [LAYERS];
	int  stack_slot [LAYERS];
	int  top_level_now;

	layer_result_t pending_results[$];
	layer_result_t last_result;
	bit  pacing = 1'b1;
	int  mismatch_count = 0;
	int  results_seen = 0;
	int  cycle_count = 0;

	layer_order_table #(.MAX_LAYERS(LAYERS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .layer_id(layer_id), .height_request(height_request),
		.out_valid(out_valid), .out_stall(out_stall),
		.alloc_ok(alloc_ok), .allocated_id(allocated_id),
		.layer_height(layer_height), .top_height(top_height),
		.redraw_valid(redraw_valid), .map_from_layer(map_from_layer),
		.redraw_low(redraw_low), .redraw_high(redraw_high)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int slot_at(int h);
		if (h < 0 || h >= LAYERS)
			return 0;
		return stack_slot[h];
	endfunction

	function automatic void slot_store(int h, int id);
		if (h < 0 || h >= LAYERS || id >= LAYERS)
			return;
		stack_slot[h] = id;
		layer_level[id] = h;
	endfunction

	// Move one layer to a clamped height; returns 1 when the order changed
	function automatic bit restack_layer(int id, int req, output int map_from,
			output int low, output int high);
		int old;
		int limit;
		int nh;
		int h;
		old = layer_level[id];
		limit = (old >= 0) ? top_level_now : top_level_now + 1;
		nh = req;
		map_from = 0;
		low = 0;
		high = -1;
		if (nh > limit)
			nh = limit;
		if (nh < -1)
			nh = -1;
		if (nh == old)
			return 1'b0;
		if (old > nh) begin
			if (nh >= 0) begin
				// lower: layers in between move up one
				for (h = old; h > nh; h--)
					slot_store(h, slot_at(h - 1));
				slot_store(nh, id);
				map_from = nh + 1;
				low = nh + 1;
				high = old;
			end else begin
				// hide: layers above move down one
				for (h = old; h < top_level_now; h++)
					slot_store(h, slot_at(h + 1));
				layer_level[id] = -1;
				top_level_now--;
				map_from = 0;
				low = 0;
				high = old - 1;
			end
		end else begin
			if (old >= 0) begin
				for (h = old; h < nh; h++)
					slot_store(h, slot_at(h + 1));
			end else begin
				for (h = top_level_now; h >= nh; h--)
					slot_store(h + 1, slot_at(h));
				top_level_now++;
			end
			slot_store(nh, id);
			map_from = nh;
			low = nh;
			high = nh;
		end
		return 1'b1;
	endfunction

	// Advance the predicted state by one command and build its result
	function automatic layer_result_t apply_command(lot_mode_t m, logic [3:0] id_in,
			logic signed [5:0] req_in);
		layer_result_t r;
		int id;
		int req;
		int lh;
		int map_from;
		int low;
		int high;
		bit changed;
		bit id_live;
		id = id_in;
		req = req_in;
		lh = -1;
		map_from = 0;
		low = 0;
		high = -1;
		changed = 1'b0;
		r.alloc_ok = 1'b0;
		r.allocated_id = '0;
		id_live = layer_claimed[id];
		if (m == MODE_ALLOC) begin
			for (int i = 0; i < LAYERS; i++) begin
				if (!layer_claimed[i]) begin
					layer_claimed[i] = 1'b1;
					layer_level[i] = -1;
					r.alloc_ok = 1'b1;
					r.allocated_id = i[3:0];
					break;
				end
			end
		end else if (m == MODE_SET && id_live) begin
			changed = restack_layer(id, req, map_from, low, high);
			lh = layer_level[id];
		end else if (m == MODE_FREE && id_live) begin
			if (layer_level[id] >= 0)
				changed = restack_layer(id, -1, map_from, low, high);
			layer_claimed[id] = 1'b0;
			lh = -1;
		end else begin
			lh = layer_level[id];
		end
		if (!changed) begin
			map_from = 0;
			low = 0;
			high = -1;
		end
		r.layer_height = lh[4:0];
		r.top_height = top_level_now[4:0];
		r.redraw_valid = changed;
		r.map_from_layer = map_from[3:0];
		r.redraw_low = low[3:0];
		r.redraw_high = high[4:0];
		return r;
	endfunction

	function automatic int claimed_count();
		int n;
		n = 0;
		for (int i = 0; i < LAYERS; i++)
			n += layer_claimed[i];
		return n;
	endfunction

	// Random claimed layer id, or -1 when none is claimed
	function automatic int pick_claimed();
		int ids[$];
		for (int i = 0; i < LAYERS; i++)
			if (layer_claimed[i])
				ids.push_back(i);
		if (ids.size() == 0)
			return -1;
		return ids[$urandom_range(0, ids.size() - 1)];
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("result %0d: %s is %0d, expected %0d", results_seen, field, got, want);
		mismatch_count++;
	endtask

	// Drive one request, hold it until taken, then predict its result
	task automatic send_request(lot_mode_t m, logic [3:0] id, logic signed [5:0] req);
		int gap;
		gap = pacing ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mode <= m;
		layer_id <= id;
		height_request <= req;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		last_result = apply_command(m, id, req);
		pending_results.push_back(last_result);
	endtask

	task automatic send_random(bit noise);
		int pick;
		int id;
		if (noise) begin
			send_request(lot_mode_t'(2'($urandom_range(0, 3))), 4'($urandom_range(0, 15)),
				6'($urandom_range(0, 63)));
			return;
		end
		pick = $urandom_range(0, 9);
		id = pick_claimed();
		if (claimed_count() < 3 && pick >= 8)
			pick = 0;
		if (claimed_count() > 13 && pick <= 1)
			pick = 9;
		if (pick <= 1 || id < 0) begin
			send_request(MODE_ALLOC, 4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)));
		end else if (pick <= 7) begin
			send_request(MODE_SET, 4'(id), 6'($urandom_range(0, top_level_now + 3) - 1));
		end else begin
			send_request(MODE_FREE, 4'(id), 6'($urandom_range(0, 63)));
		end
	endtask

	// Commands on unclaimed layers and the unused mode change nothing
	task automatic test_ignored_commands();
		send_request(MODE_SET, 4'd5, 6'sd0);
		send_request(MODE_NONE, 4'd15, 6'sd31);
		send_request(MODE_FREE, 4'd0, -6'sd32);
		send_request(MODE_NONE, 4'd0, -6'sd1);
	endtask

	// Show, lower, raise, hide, clamp and free on a small stack
	task automatic test_directed_reorder();
		send_request(MODE_ALLOC, 4'd15, -6'sd1);
		send_request(MODE_ALLOC, 4'd0, 6'sd0);
		send_request(MODE_ALLOC, 4'd9, 6'sd21);
		send_request(MODE_SET, 4'd0, 6'sd31);      // clamp to top+1: show at 0
		send_request(MODE_SET, 4'd1, 6'sd0);       // show below layer 0
		send_request(MODE_SET, 4'd2, 6'sd16);      // clamp to top+1
		send_request(MODE_SET, 4'd2, 6'sd2);       // same height
		send_request(MODE_SET, 4'd2, 6'sd0);       // lower to bottom
		send_request(MODE_SET, 4'd0, -6'sd32);     // hide from the top
		send_request(MODE_SET, 4'd2, 6'sd15);      // raise, clamped to top
		send_request(MODE_SET, 4'd1, -6'sd1);      // hide the bottom layer
		send_request(MODE_SET, 4'd0, -6'sd1);      // already hidden
		send_request(MODE_SET, 4'd0, 6'sd0);       // show under layer 2
		send_request(MODE_FREE, 4'd2, 6'sd0);      // free a shown layer
		send_request(MODE_FREE, 4'd1, 6'sd0);      // free a hidden layer
		send_request(MODE_SET, 4'd1, 6'sd3);       // freed layer ignored
		send_request(MODE_FREE, 4'd0, 6'sd0);
	endtask

	// Fill the table past capacity, then release every layer
	task automatic test_fill_and_drain();
		int id;
		for (int i = 0; i <= LAYERS; i++) begin
			send_request(MODE_ALLOC, 4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)));
			if (last_result.alloc_ok)
				send_request(MODE_SET, last_result.allocated_id,
					6'($urandom_range(0, top_level_now + 2) - 1));
		end
		for (int i = 0; i < LAYERS; i++) begin
			if ($urandom_range(0, 1))
				send_random(1'b0);
			id = pick_claimed();
			if (id >= 0)
				send_request(MODE_FREE, 4'(id), 6'($urandom_range(0, 63)));
		end
		while (pick_claimed() >= 0)
			send_request(MODE_FREE, 4'(pick_claimed()), 6'sd0);
	endtask

	// Mostly well-formed command streams with random content, some noise
	task automatic test_random_commands(int count);
		for (int i = 0; i < count; i++)
			send_random($urandom_range(0, 4) == 0);
	endtask

	// Take results, stall at random, compare against the oldest prediction
	initial begin
		int hold;
		layer_result_t want;
		@(posedge arst_n);
		forever begin
			hold = pacing ? $urandom_range(0, 5) : 0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do
				@(posedge clk);
			while (out_valid !== 1'b1);
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (alloc_ok !== want.alloc_ok)
					report_mismatch("alloc_ok", alloc_ok, want.alloc_ok);
				if (allocated_id !== want.allocated_id)
					report_mismatch("allocated_id", allocated_id, want.allocated_id);
				if (layer_height !== want.layer_height)
					report_mismatch("layer_height", layer_height, want.layer_height);
				if (top_height !== want.top_height)
					report_mismatch("top_height", top_height, want.top_height);
				if (redraw_valid !== want.redraw_valid)
					report_mismatch("redraw_valid", redraw_valid, want.redraw_valid);
				if (map_from_layer !== want.map_from_layer)
					report_mismatch("map_from_layer", map_from_layer, want.map_from_layer);
				if (redraw_low !== want.redraw_low)
					report_mismatch("redraw_low", redraw_low, want.redraw_low);
				if (redraw_high !== want.redraw_high)
					report_mismatch("redraw_high", redraw_high, want.redraw_high);
			end
		end
	end

	initial begin
		for (int i = 0; i < LAYERS; i++) begin
			layer_claimed[i] = 1'b0;
			layer_level[i] = -1;
			stack_slot[i] = 0;
		end
		top_level_now = -1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ignored_commands();
		test_directed_reorder();
		test_random_commands(300);
		pacing = 1'b0;
		test_random_commands(150);
		pacing = 1'b1;
		test_fill_and_drain();
		test_random_commands(150);

		// Drain outstanding results
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
